// File: design/wavhp_pkg.sv
`timescale 1ns / 1ps

package wavhp_pkg;

  // field widths of the result
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned BITS_W  = 16;
  localparam int unsigned SSIZE_W = 13;
  localparam int unsigned COUNT_W = SIZE_W + 3;

  // bit-serial divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = COUNT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // chunk tags, little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [23:0] TAG_FMT3 = 24'h74_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MAX  = 32'd16;
  localparam logic [31:0] PCM_CODE = 32'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_RIFF  = 3'd1,
    ST_NO_WAVE  = 3'd2,
    ST_NO_FMT   = 3'd3,
    ST_FMT_LONG = 3'd4,
    ST_NOT_PCM  = 3'd5,
    ST_TRUNC    = 3'd6
  } wavhp_status_t;

  // parser phases, one-hot
  typedef enum logic [13:0] {
    PH_RIFF    = 14'b00000000000001,
    PH_RSIZE   = 14'b00000000000010,
    PH_WAVE    = 14'b00000000000100,
    PH_FMTID   = 14'b00000000001000,
    PH_FMTSIZE = 14'b00000000010000,
    PH_AFMT    = 14'b00000000100000,
    PH_CHAN    = 14'b00000001000000,
    PH_RATE    = 14'b00000010000000,
    PH_BRATE   = 14'b00000100000000,
    PH_ALIGN   = 14'b00001000000000,
    PH_BITS    = 14'b00010000000000,
    PH_CID     = 14'b00100000000000,
    PH_CSIZE   = 14'b01000000000000,
    PH_SKIP    = 14'b10000000000000
  } wavhp_phase_t;

  // controller to datapath
  typedef struct packed {
    logic          shift_en;
    logic [1:0]    byte_idx;
    logic          byte_en;
    logic          file_end;
    logic          cap_chan;
    logic          cap_rate;
    logic          cap_brate;
    logic          cap_align;
    logic          cap_bits;
    logic          cap_cid;
    logic          load_skip;
    logic          dec_skip;
    logic          emit_err;
    wavhp_status_t err_code;
    logic          emit_ok;
  } wavhp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic w_riff;
    logic w_wave;
    logic w_fmt3;
    logic w_gt_max;
    logic w_pcm;
    logic w_zero;
    logic chunk_data;
    logic skip_end;
    logic div_busy;
    logic div_done;
  } wavhp_stat_t;

endpackage

// File: design/wavhp_div.sv
`timescale 1ns / 1ps

module wavhp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wavhp_pkg::COUNT_W-1:0] dividend,
  input  logic [wavhp_pkg::BITS_W-1:0]  divisor,
  output logic                         busy,
  output logic                         done,
  output logic [wavhp_pkg::COUNT_W-1:0] quotient
);
  import wavhp_pkg::*;

  logic [BITS_W-1:0]    rem_r, rem_nxt;
  logic [COUNT_W-1:0]   quo_r, quo_nxt;
  logic [BITS_W-1:0]    dvs_r, dvs_nxt;
  logic                 zero_r, zero_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [BITS_W:0]      trial;
  logic [BITS_W:0]      diff;
  logic                 fits;

  // restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[COUNT_W-1]};
    fits  = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    zero_nxt = zero_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      zero_nxt = (divisor == '0);
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[BITS_W-1:0] : trial[BITS_W-1:0];
      quo_nxt = {quo_r[COUNT_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    zero_r <= zero_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = zero_r ? '0 : quo_r;

endmodule

// File: design/wavhp_dp.sv
`timescale 1ns / 1ps

module wavhp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    data_byte,
  input  wavhp_pkg::wavhp_cmd_t         cmd,
  output wavhp_pkg::wavhp_stat_t        stat,
  output logic [2:0]                    o_status,
  output logic [15:0]                   o_num_channels,
  output logic [31:0]                   o_sample_rate,
  output logic [31:0]                   o_byte_rate,
  output logic [15:0]                   o_block_align,
  output logic [15:0]                   o_bits_per_sample,
  output logic [31:0]                   o_data_size,
  output logic [31:0]                   o_data_offset,
  output logic [wavhp_pkg::SSIZE_W-1:0] o_sample_size,
  output logic [wavhp_pkg::COUNT_W-1:0] o_samples_count
);
  import wavhp_pkg::*;

  logic [31:0]         shift_r;
  logic [31:0]         skip_r;
  logic [31:0]         pos_r, pos_nxt;
  logic                chunk_data_r;
  logic [15:0]         chan_r;
  logic [31:0]         rate_r;
  logic [31:0]         brate_r;
  logic [15:0]         align_r;
  logic [BITS_W-1:0]   bits_r;
  logic [31:0]         w;

  logic [2:0]          st_r;
  logic [15:0]         ochan_r;
  logic [31:0]         orate_r;
  logic [31:0]         obrate_r;
  logic [15:0]         oalign_r;
  logic [BITS_W-1:0]   obits_r;
  logic [SIZE_W-1:0]   osize_r;
  logic [31:0]         ooffs_r;
  logic [SSIZE_W-1:0]  ossize_r;
  logic [COUNT_W-1:0]  ocount_r;

  logic                div_busy;
  logic                div_done;
  logic [COUNT_W-1:0]  div_q;

  // word assembly, little-endian
  always_comb begin
    case (cmd.byte_idx)
      2'd0:    w = {24'd0, data_byte};
      2'd1:    w = shift_r | {16'd0, data_byte, 8'd0};
      2'd2:    w = shift_r | {8'd0, data_byte, 16'd0};
      2'd3:    w = shift_r | {data_byte, 24'd0};
      default: w = {24'd0, data_byte};
    endcase
  end

  // byte position, wraps at 32 bits, cleared at end of file
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.byte_en) begin
      pos_nxt = cmd.file_end ? 32'd0 : pos_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // header fields and chunk walking
  always_ff @(posedge clk) begin
    if (cmd.shift_en) shift_r <= w;
    if (cmd.cap_chan) chan_r <= w[15:0];
    if (cmd.cap_rate) rate_r <= w;
    if (cmd.cap_brate) brate_r <= w;
    if (cmd.cap_align) align_r <= w[15:0];
    if (cmd.cap_bits) bits_r <= w[BITS_W-1:0];
    if (cmd.cap_cid) chunk_data_r <= (w == TAG_DATA);
    if (cmd.load_skip) begin
      skip_r <= w;
    end else if (cmd.dec_skip) begin
      skip_r <= skip_r - 32'd1;
    end
  end

  // sample count divider
  wavhp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.emit_ok),
    .dividend ({w, 3'b000}),
    .divisor  (bits_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      st_r     <= cmd.err_code;
      ochan_r  <= '0;
      orate_r  <= '0;
      obrate_r <= '0;
      oalign_r <= '0;
      obits_r  <= '0;
      osize_r  <= '0;
      ooffs_r  <= '0;
      ossize_r <= '0;
      ocount_r <= '0;
    end else if (cmd.emit_ok) begin
      st_r     <= ST_OK;
      ochan_r  <= chan_r;
      orate_r  <= rate_r;
      obrate_r <= brate_r;
      oalign_r <= align_r;
      obits_r  <= bits_r;
      osize_r  <= w;
      ooffs_r  <= pos_r + 32'd1;
      ossize_r <= bits_r[BITS_W-1:3];
    end
    if (div_done) ocount_r <= div_q;
  end

  always_comb begin
    stat.w_riff     = (w == TAG_RIFF);
    stat.w_wave     = (w == TAG_WAVE);
    stat.w_fmt3     = (w[23:0] == TAG_FMT3);
    stat.w_gt_max   = (w > FMT_MAX);
    stat.w_pcm      = (w == PCM_CODE);
    stat.w_zero     = (w == 32'd0);
    stat.chunk_data = chunk_data_r;
    stat.skip_end   = (skip_r == 32'd1);
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
  end

  assign o_status          = st_r;
  assign o_num_channels    = ochan_r;
  assign o_sample_rate     = orate_r;
  assign o_byte_rate       = obrate_r;
  assign o_block_align     = oalign_r;
  assign o_bits_per_sample = obits_r;
  assign o_data_size       = osize_r;
  assign o_data_offset     = ooffs_r;
  assign o_sample_size     = ossize_r;
  assign o_samples_count   = ocount_r;

endmodule

// File: design/wavhp_ctrl.sv
`timescale 1ns / 1ps

module wavhp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_is_last,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wavhp_pkg::wavhp_cmd_t  cmd,
  input  wavhp_pkg::wavhp_stat_t stat
);
  import wavhp_pkg::*;

  wavhp_phase_t phase_r, phase_nxt;
  logic [1:0]   k_r, k_nxt;
  logic         fin_r, fin_nxt;
  logic         ovld_r, ovld_nxt;
  logic         acc;
  logic         short_fld;
  logic         fld_done;

  // hold off while the divider runs or finishes, or while a result waits under out_stall
  assign in_stall = stat.div_busy | stat.div_done | (ovld_r & out_stall);
  assign acc      = in_valid & ~in_stall;

  always_comb begin
    short_fld = (phase_r == PH_AFMT) || (phase_r == PH_CHAN) ||
                (phase_r == PH_ALIGN) || (phase_r == PH_BITS);
    fld_done  = short_fld ? (k_r == 2'd1) : (k_r == 2'd3);
  end

  // parser sequencing
  always_comb begin
    phase_nxt = phase_r;
    k_nxt     = k_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    cmd.byte_idx = k_r;
    cmd.err_code = ST_OK;
    cmd.byte_en  = acc;
    if (acc && !fin_r) begin
      if (phase_r == PH_SKIP) begin
        cmd.dec_skip = 1'b1;
        if (stat.skip_end) begin
          phase_nxt = PH_CID;
          k_nxt     = 2'd0;
        end
      end else begin
        cmd.shift_en = 1'b1;
        if (!fld_done) begin
          k_nxt = k_r + 2'd1;
        end else begin
          k_nxt = 2'd0;
          case (phase_r)
            PH_RIFF: begin
              if (!stat.w_riff) begin
                cmd.emit_err = 1'b1;
                cmd.err_code = ST_NO_RIFF;
              end else phase_nxt = PH_RSIZE;
            end
            PH_RSIZE: phase_nxt = PH_WAVE;
            PH_WAVE: begin
              if (!stat.w_wave) begin
                cmd.emit_err = 1'b1;
                cmd.err_code = ST_NO_WAVE;
              end else phase_nxt = PH_FMTID;
            end
            PH_FMTID: begin
              if (!stat.w_fmt3) begin
                cmd.emit_err = 1'b1;
                cmd.err_code = ST_NO_FMT;
              end else phase_nxt = PH_FMTSIZE;
            end
            PH_FMTSIZE: begin
              if (stat.w_gt_max) begin
                cmd.emit_err = 1'b1;
                cmd.err_code = ST_FMT_LONG;
              end else phase_nxt = PH_AFMT;
            end
            PH_AFMT: begin
              if (!stat.w_pcm) begin
                cmd.emit_err = 1'b1;
                cmd.err_code = ST_NOT_PCM;
              end else phase_nxt = PH_CHAN;
            end
            PH_CHAN: begin
              cmd.cap_chan = 1'b1;
              phase_nxt    = PH_RATE;
            end
            PH_RATE: begin
              cmd.cap_rate = 1'b1;
              phase_nxt    = PH_BRATE;
            end
            PH_BRATE: begin
              cmd.cap_brate = 1'b1;
              phase_nxt     = PH_ALIGN;
            end
            PH_ALIGN: begin
              cmd.cap_align = 1'b1;
              phase_nxt     = PH_BITS;
            end
            PH_BITS: begin
              cmd.cap_bits = 1'b1;
              phase_nxt    = PH_CID;
            end
            PH_CID: begin
              cmd.cap_cid = 1'b1;
              phase_nxt   = PH_CSIZE;
            end
            PH_CSIZE: begin
              if (stat.chunk_data) begin
                cmd.emit_ok = 1'b1;
                fin_nxt     = 1'b1;
              end else if (stat.w_zero) begin
                phase_nxt = PH_CID;
              end else begin
                cmd.load_skip = 1'b1;
                phase_nxt     = PH_SKIP;
              end
            end
            default: phase_nxt = PH_RIFF;
          endcase
          if (cmd.emit_err) fin_nxt = 1'b1;
        end
      end
    end
    // end of file: report truncation if no result was given yet, and rearm
    if (acc && in_is_last) begin
      if (!fin_nxt) begin
        cmd.emit_err = 1'b1;
        cmd.err_code = ST_TRUNC;
      end
      cmd.file_end = 1'b1;
      phase_nxt    = PH_RIFF;
      k_nxt        = 2'd0;
      fin_nxt      = 1'b0;
    end
  end

  // result valid: errors at once, success when the count is ready
  always_comb begin
    ovld_nxt = ovld_r & out_stall;
    if (cmd.emit_err || stat.div_done) ovld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      k_r     <= 2'd0;
      fin_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      fin_r   <= fin_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;

`ifndef SYNTHESIS
  // a data chunk header starts the divider
  a_ok_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ok |=> stat.div_busy)
    else $error("divider not started after data chunk header");

  // success and error are never reported in the same cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_ok && cmd.emit_err))
    else $error("success and error reported together");

  // a finished count never lands on a pending result
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !ovld_r)
    else $error("division finished while a result was pending");

  // last byte rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_is_last) |=> (phase_r == PH_RIFF && !fin_r && k_r == 2'd0))
    else $error("parser not rearmed after last byte");
`endif

endmodule

// File: design/wav_header_parser.sv
`timescale 1ns / 1ps

// RIFF/WAVE PCM header parser. Takes a file one byte per request and gives one
// result per file: success with the fmt fields, data chunk size and offset,
// or the first error, or truncation when is_last comes before the data chunk
// header. While parsing, a byte is taken every cycle unless the input is
// stalled. After the data chunk header the sample count comes from a
// bit-serial divider, one quotient bit a cycle; the input is stalled until it
// is done, and the success result follows; error results appear the cycle
// after their byte. A result waits in an output register; the input is also
// stalled while that register is full and out_stall is high. Bytes after a
// result are ignored until is_last, which rearms the parser.
module wav_header_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [15:0]                   out_num_channels,
  output logic [31:0]                   out_sample_rate,
  output logic [31:0]                   out_byte_rate,
  output logic [15:0]                   out_block_align,
  output logic [15:0]                   out_bits_per_sample,
  output logic [31:0]                   out_data_size,
  output logic [31:0]                   out_data_offset,
  output logic [wavhp_pkg::SSIZE_W-1:0] out_sample_size,
  output logic [wavhp_pkg::COUNT_W-1:0] out_samples_count
);
  import wavhp_pkg::*;

  wavhp_cmd_t  cmd;
  wavhp_stat_t stat;

  wavhp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  wavhp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .data_byte         (in_data_byte),
    .cmd               (cmd),
    .stat              (stat),
    .o_status          (out_status),
    .o_num_channels    (out_num_channels),
    .o_sample_rate     (out_sample_rate),
    .o_byte_rate       (out_byte_rate),
    .o_block_align     (out_block_align),
    .o_bits_per_sample (out_bits_per_sample),
    .o_data_size       (out_data_size),
    .o_data_offset     (out_data_offset),
    .o_sample_size     (out_sample_size),
    .o_samples_count   (out_samples_count)
  );

endmodule
